// ===== rtl/rama_pkg.sv =====
// Shared constants and types for the rational add/multiply/divide reducer.
`timescale 1ns / 1ps

package rama_pkg;

  localparam int unsigned IN_WIDTH_DEF = 16;
  localparam int unsigned NUM_W = 33;
  localparam int unsigned DEN_W = 31;
  localparam int unsigned OP_W = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_MUL = 2'd1;
  localparam logic [OP_W-1:0] OP_DIV = 2'd2;
  localparam logic [OP_W-1:0] OP_RSV = 2'd3;

  typedef enum logic [1:0] {
    MUL_X,
    MUL_Y,
    MUL_Z
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     comb;
    logic     prep;
    logic     gcd_step;
    logic     div_start;
    logic     div_den;
    logic     div_step;
    logic     save_num;
    logic     out_load;
  } rama_cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } rama_sts_t;

endpackage

// ===== rtl/rama_if.sv =====
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface rama_req_if #(
  parameter int unsigned IN_WIDTH = rama_pkg::IN_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [rama_pkg::OP_W-1:0]   op;
  logic signed [IN_WIDTH-1:0]  a_num;
  logic [IN_WIDTH-2:0]         a_den;
  logic signed [IN_WIDTH-1:0]  b_num;
  logic [IN_WIDTH-2:0]         b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rama_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [rama_pkg::NUM_W-1:0] res_num;
  logic [rama_pkg::DEN_W-1:0]        res_den;
  logic                             error;

  modport source (output valid, res_num, res_den, error, input ready);
  modport sink (input valid, res_num, res_den, error, output ready);
endinterface

// ===== rtl/rama_ctrl.sv =====
// Sequencing state machine for the rational reducer.
`timescale 1ns / 1ps

module rama_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rama_pkg::rama_cmd_t cmd_o,
  input  rama_pkg::rama_sts_t sts_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_COMB = 4'd4;
  localparam logic [3:0] S_PREP = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIVN = 4'd7;
  localparam logic [3:0] S_DIVD = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rama_pkg::MUL_X;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rama_pkg::MUL_Y;
        state_d       = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = rama_pkg::MUL_Z;
        state_d       = S_COMB;
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.err ? S_OUT : S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIVN;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIVN: begin
        if (sts_i.div_done) begin
          cmd_o.save_num  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_den   = 1'b1;
          state_d         = S_DIVD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DIVD: begin
        if (sts_i.div_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/rama_dp.sv =====
// Datapath: shared multiplier, binary GCD, restoring divider, result register.
`timescale 1ns / 1ps

module rama_dp #(
  parameter int unsigned IN_WIDTH = rama_pkg::IN_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rama_pkg::OP_W-1:0]        op_i,
  input  logic signed [IN_WIDTH-1:0]       a_num_i,
  input  logic [IN_WIDTH-2:0]              a_den_i,
  input  logic signed [IN_WIDTH-1:0]       b_num_i,
  input  logic [IN_WIDTH-2:0]              b_den_i,
  input  rama_pkg::rama_cmd_t              cmd_i,
  output rama_pkg::rama_sts_t              sts_o,
  output logic signed [rama_pkg::NUM_W-1:0] res_num_o,
  output logic [rama_pkg::DEN_W-1:0]       res_den_o,
  output logic                             error_o
);

  localparam int unsigned MW = 2 * IN_WIDTH;
  localparam int unsigned KW = $clog2(MW + 1);
  localparam int unsigned PW = 2 * IN_WIDTH + 2;
  localparam int unsigned NW = rama_pkg::NUM_W;
  localparam int unsigned DW = rama_pkg::DEN_W;
  localparam int unsigned XW = (MW + 1 > NW) ? MW + 1 : NW;
  localparam int unsigned YW = (MW > DW) ? MW : DW;

  logic [rama_pkg::OP_W-1:0] op_q;
  logic [IN_WIDTH-1:0]       an_q, bn_q;
  logic [IN_WIDTH-2:0]       ad_q, bd_q;
  logic [MW-1:0]             px_q, py_q, pz_q;
  logic [MW-1:0]             n_q, d_q;
  logic                      err_q;
  logic                      neg_q, triv_q;
  logic [MW-1:0]             u_q, v_q;
  logic [KW-1:0]             k_q;
  logic [MW-1:0]             rem_q, quo_q, dvs_q, qn_q;
  logic [KW-1:0]             cnt_q;
  logic signed [NW-1:0]      num_q;
  logic [DW-1:0]             den_q;
  logic                      eout_q;

  logic signed [IN_WIDTH:0]  ma, mb;
  logic signed [PW-1:0]      prod;
  logic [MW-1:0]             n_w, d_w, nm_w, dm_w, g_w;
  logic                      err_w;
  logic [MW:0]               rem_sh, diff;
  logic                      ge;
  logic [XW-1:0]             qx, sx;
  logic [YW-1:0]             dx;

  always_comb begin
    unique case (cmd_i.mul_sel)
      rama_pkg::MUL_X: begin
        ma = {an_q[IN_WIDTH-1], an_q};
        mb = (op_q == rama_pkg::OP_MUL) ? {bn_q[IN_WIDTH-1], bn_q} : {2'b00, bd_q};
      end
      rama_pkg::MUL_Y: begin
        ma = {2'b00, ad_q};
        mb = {bn_q[IN_WIDTH-1], bn_q};
      end
      default: begin
        ma = {2'b00, ad_q};
        mb = {2'b00, bd_q};
      end
    endcase
    prod = ma * mb;
  end

  assign n_w   = (op_q == rama_pkg::OP_ADD) ? px_q + py_q : px_q;
  assign d_w   = (op_q == rama_pkg::OP_DIV) ? py_q : pz_q;
  assign err_w = (op_q == rama_pkg::OP_RSV) || (d_w == '0) ||
                 ((op_q == rama_pkg::OP_DIV) && (bn_q == '0));
  assign nm_w  = n_q[MW-1] ? MW'(0) - n_q : n_q;
  assign dm_w  = d_q[MW-1] ? MW'(0) - d_q : d_q;
  assign g_w   = triv_q ? MW'(1) : ((u_q | v_q) << k_q);

  assign rem_sh = {rem_q, quo_q[MW-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  assign sts_o.err      = err_q;
  assign sts_o.gcd_done = (u_q == '0) || (v_q == '0);
  assign sts_o.div_done = (cnt_q == KW'(MW));

  assign qx = XW'(qn_q);
  assign sx = neg_q ? XW'(0) - qx : qx;
  assign dx = YW'(quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (cmd_i.mul_en) begin
      unique case (cmd_i.mul_sel)
        rama_pkg::MUL_X: px_q <= prod[MW-1:0];
        rama_pkg::MUL_Y: py_q <= prod[MW-1:0];
        default:         pz_q <= prod[MW-1:0];
      endcase
    end
    if (cmd_i.comb) begin
      n_q   <= n_w;
      d_q   <= d_w;
      err_q <= err_w;
    end
    if (cmd_i.prep) begin
      u_q    <= nm_w;
      v_q    <= dm_w;
      k_q    <= '0;
      neg_q  <= n_q[MW-1] ^ d_q[MW-1];
      triv_q <= (nm_w == '0) || (dm_w == '0);
    end else if (cmd_i.gcd_step) begin
      priority if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
    if (cmd_i.save_num) begin
      qn_q <= quo_q;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= cmd_i.div_den ? dm_w : nm_w;
      cnt_q <= '0;
      if (!cmd_i.div_den) begin
        dvs_q <= g_w;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[MW-1:0] : rem_sh[MW-1:0];
      quo_q <= {quo_q[MW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eout_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      eout_q <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      num_q <= err_q ? '0 : sx[NW-1:0];
      den_q <= err_q ? '0 : dx[DW-1:0];
    end
  end

  assign res_num_o = num_q;
  assign res_den_o = den_q;
  assign error_o   = eout_q;

endmodule

// ===== rtl/rational_add_mul_div_reduce.sv =====
// Top level of the rational add/multiply/divide unit with GCD reduction.
//
//   port    dir  payload                              handshake
//   req_i   in   op, a_num, a_den, b_num, b_den       valid/ready
//   res_o   out  res_num, res_den, error               valid/ready
//
// One request at a time; MW = 2*IN_WIDTH. Steps per request: accept, 3 multiplies,
// combine, setup, binary GCD (one step a cycle, until either operand is zero), two
// restoring divisions (numerator, then denominator) on one shared divider, output.
// Error requests skip the GCD and both divisions and go from setup to output.
// Reset is asynchronous, active low. A stalled result holds in the output
// register; a new request is taken meanwhile and waits at its output step.
`timescale 1ns / 1ps

module rational_add_mul_div_reduce #(
  parameter int unsigned IN_WIDTH = rama_pkg::IN_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rama_req_if.sink    req_i,
  rama_res_if.source  res_o
);

  rama_pkg::rama_cmd_t cmd;
  rama_pkg::rama_sts_t sts;

  rama_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rama_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (req_i.op),
    .a_num_i   (req_i.a_num),
    .a_den_i   (req_i.a_den),
    .b_num_i   (req_i.b_num),
    .b_den_i   (req_i.b_den),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_num_o (res_o.res_num),
    .res_den_o (res_o.res_den),
    .error_o   (res_o.error)
  );

endmodule

// ===== rtl/rama_chk.sv =====
// Port-level checker for the rational reducer, bound to the top level.
`timescale 1ns / 1ps

module rama_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [rama_pkg::NUM_W-1:0] res_num_i,
  input logic [rama_pkg::DEN_W-1:0]        res_den_i,
  input logic                              error_i
);

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && error_i) |-> (res_num_i == '0 && res_den_i == '0))
    else $error("error result carries nonzero fields");

  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !error_i) |-> (res_den_i != '0))
    else $error("valid result with zero denominator");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken while busy");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(res_num_i) && $stable(res_den_i) && $stable(error_i)))
    else $error("stalled result changed");

endmodule

bind rational_add_mul_div_reduce rama_chk u_rama_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .res_num_i   (res_o.res_num),
  .res_den_i   (res_o.res_den),
  .error_i     (res_o.error)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the rational add/multiply/divide reducer.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned W = rama_pkg::IN_WIDTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1530;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [rama_pkg::OP_W-1:0] op;
    logic signed [W-1:0]       a_num;
    logic [W-2:0]              a_den;
    logic signed [W-1:0]       b_num;
    logic [W-2:0]              b_den;
  } request_t;

  typedef struct packed {
    logic signed [rama_pkg::NUM_W-1:0] res_num;
    logic [rama_pkg::DEN_W-1:0]        res_den;
    logic                              error;
  } fraction_t;

  logic clk_i;
  logic rst_ni;

  rama_req_if #(.IN_WIDTH(W)) req_if ();
  rama_res_if res_if ();

  rational_add_mul_div_reduce #(.IN_WIDTH(W)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  request_t  pending_reqs[$];
  fraction_t expected_fracs[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned error_results;
  longint unsigned cycle_count;
  bit hold_off;
  bit steady;
  bit stimulus_done;

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_t reduce_fraction(request_t r);
    fraction_t f;
    longint an, ad, bn, bd, n, d;
    longint unsigned nm, dm, g;
    logic neg;
    an = longint'(r.a_num);
    ad = longint'(r.a_den);
    bn = longint'(r.b_num);
    bd = longint'(r.b_den);
    f = '0;
    case (r.op)
      rama_pkg::OP_ADD: begin
        n = an * bd + ad * bn;
        d = ad * bd;
      end
      rama_pkg::OP_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      rama_pkg::OP_DIV: begin
        n = an * bd;
        d = ad * bn;
      end
      default: begin
        n = 0;
        d = 0;
      end
    endcase
    if (r.op == rama_pkg::OP_RSV || d == 0) begin
      f.error = 1'b1;
      return f;
    end
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    neg = (n < 0) != (d < 0);
    g = 1;
    if (nm != 0 && dm != 0) g = gcd_of(nm, dm);
    nm = nm / g;
    dm = dm / g;
    f.res_num = rama_pkg::NUM_W'((neg && nm != 0) ? -nm : nm);
    f.res_den = rama_pkg::DEN_W'(dm);
    return f;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    r.op = (mode == 0) ? rama_pkg::OP_RSV :
           rama_pkg::OP_W'($urandom_range(rama_pkg::OP_ADD, rama_pkg::OP_DIV));
    r.a_num = W'($urandom);
    r.b_num = W'($urandom);
    r.a_den = (W - 1)'($urandom_range(1, 32767));
    r.b_den = (W - 1)'($urandom_range(1, 32767));
    if (mode == 1) begin
      r.a_num = W'($urandom_range(0, 40)) - W'(20);
      r.b_num = W'($urandom_range(0, 40)) - W'(20);
      r.a_den = (W - 1)'($urandom_range(1, 30));
      r.b_den = (W - 1)'($urandom_range(1, 30));
    end else if (mode == 2) begin
      r.b_num = '0;
    end else if (mode == 3) begin
      r.a_den = r.b_den;
      r.a_num = W'($urandom_range(1, 12)) * W'(r.b_den[7:0]);
    end
    return r;
  endfunction

  task automatic add_request(logic [rama_pkg::OP_W-1:0] op, int an, int ad, int bn, int bd);
    request_t r;
    r.op = op;
    r.a_num = W'(an);
    r.a_den = (W - 1)'(ad);
    r.b_num = W'(bn);
    r.b_den = (W - 1)'(bd);
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    add_request(rama_pkg::OP_ADD, 1, 2, 1, 3);
    add_request(rama_pkg::OP_ADD, 1, 2, -1, 2);
    add_request(rama_pkg::OP_ADD, -32768, 1, -32768, 1);
    add_request(rama_pkg::OP_ADD, 32767, 32767, 32767, 32767);
    add_request(rama_pkg::OP_ADD, -32768, 32767, 32767, 1);
    add_request(rama_pkg::OP_MUL, -32768, 1, -32768, 1);
    add_request(rama_pkg::OP_MUL, 32767, 1, -32768, 1);
    add_request(rama_pkg::OP_MUL, 0, 32767, 5, 32767);
    add_request(rama_pkg::OP_MUL, 3, 4, 4, 3);
    add_request(rama_pkg::OP_MUL, -6, 35, 14, 9);
    add_request(rama_pkg::OP_DIV, 1, 2, 0, 3);
    add_request(rama_pkg::OP_DIV, -32768, 1, 0, 32767);
    add_request(rama_pkg::OP_DIV, -32768, 32767, 1, 1);
    add_request(rama_pkg::OP_DIV, 32767, 1, -32768, 32767);
    add_request(rama_pkg::OP_DIV, 0, 5, -7, 3);
    add_request(rama_pkg::OP_DIV, 5, 3, -5, 3);
    add_request(rama_pkg::OP_RSV, 1, 1, 1, 1);
    add_request(rama_pkg::OP_RSV, 0, 32767, 0, 32767);
    add_request(rama_pkg::OP_ADD, 21845, 10922, -21846, 21845);
    add_request(rama_pkg::OP_MUL, -1, 1, -1, 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_reqs.push_back(random_request());
    stimulus_done = 1'b1;
  end

  // Driver: offer requests with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.op <= rama_pkg::OP_ADD;
      req_if.a_num <= '0;
      req_if.a_den <= '0;
      req_if.b_num <= '0;
      req_if.b_den <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_fracs.push_back(reduce_fraction(pending_reqs.pop_front()));
        sent_count++;
      end
      if ((!req_if.valid || req_if.ready) && pending_reqs.size() > 0 &&
          (steady || $urandom_range(0, 99) >= 33)) begin
        req_if.valid <= 1'b1;
        {req_if.op, req_if.a_num, req_if.a_den, req_if.b_num, req_if.b_den} <=
          pending_reqs[0];
      end else if (req_if.valid && req_if.ready) begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: check results and stall the result channel.
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        checked_count++;
        if (res_if.error) error_results++;
        if (expected_fracs.size() == 0) begin
          $error("unexpected result num=%0d den=%0d err=%0b",
                 res_if.res_num, res_if.res_den, res_if.error);
          error_count++;
        end else begin
          want = expected_fracs.pop_front();
          if (res_if.res_num !== want.res_num) begin
            $error("res_num expected %0d actual %0d", want.res_num, res_if.res_num);
            error_count++;
          end
          if (res_if.res_den !== want.res_den) begin
            $error("res_den expected %0d actual %0d", want.res_den, res_if.res_den);
            error_count++;
          end
          if (res_if.error !== want.error) begin
            $error("error expected %0b actual %0b", want.error, res_if.error);
            error_count++;
          end
        end
      end
      res_if.ready <= !hold_off && (steady || $urandom_range(0, 99) >= 33);
    end
  end

  // Hold off the result channel for a long stretch; later run it without idling for a while.
  initial begin
    hold_off = 1'b0;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    wait (sent_count >= 100);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk_i);
    hold_off = 1'b0;
    wait (sent_count >= 400);
    steady = 1'b1;
    wait (sent_count >= 600);
    steady = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && rst_ni === 1'b1);
    wait (pending_reqs.size() == 0 && !req_if.valid && expected_fracs.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Checked %0d results of %0d requests, %0d of them error results.",
             checked_count, sent_count, error_results);
    if (error_count == 0 && expected_fracs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
